>>> design/orf_pkg.sv
// ============================================================================
// orf_pkg
// Shared widths, register indexes and state codes for the three-frame open
// reading frame finder.
// ============================================================================
package orf_pkg;

    localparam int NUM_FRAMES = 3;
    localparam int FRAME_W    = 2;
    localparam int AMINO_W    = 8;
    localparam int POS_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [AMINO_W-1:0] START_CODE_RST = 8'd77;
    localparam logic [AMINO_W-1:0] STOP_CODE_RST  = 8'd42;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALL_STARTS = 2'd0,
        CFG_START_CODE = 2'd1,
        CFG_STOP_CODE  = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_LOAD = 3'b100
    } t_state;

endpackage

>>> design/orf_in_if.sv
// ============================================================================
// orf_in_if
// Input channel: one translated amino code with its frame and codon position.
// ============================================================================
interface orf_in_if;
    logic                        valid;
    logic                        ready;
    logic [orf_pkg::AMINO_W-1:0] amino;
    logic [orf_pkg::FRAME_W-1:0] reading_frame;
    logic [orf_pkg::POS_W-1:0]   codon_position;

    modport source (output valid, amino, reading_frame, codon_position, input ready);
    modport sink   (input valid, amino, reading_frame, codon_position, output ready);
endinterface

>>> design/orf_out_if.sv
// ============================================================================
// orf_out_if
// Output channel: one reported open reading frame.
// ============================================================================
interface orf_out_if;
    logic                        valid;
    logic                        ready;
    logic [orf_pkg::POS_W-1:0]   orf_begin;
    logic [orf_pkg::POS_W-1:0]   orf_finish;
    logic [orf_pkg::FRAME_W-1:0] rpt_frame;
    logic                        last_of_run;
    logic                        overflow_seen;

    modport source (output valid, orf_begin, orf_finish, rpt_frame, last_of_run,
                    overflow_seen, input ready);
    modport sink   (input valid, orf_begin, orf_finish, rpt_frame, last_of_run,
                    overflow_seen, output ready);
endinterface

>>> design/orf_finder_three_frame_top.sv
// ============================================================================
// orf_finder_three_frame_top
// Keeps a stack of start coordinates per reading frame in one synchronous
// memory and reports every stacked start when a stop codon closes the frame.
// ============================================================================
//  Channel   Direction  Content
//  i_in      sink       amino, reading_frame, codon_position
//  o_out     source     orf_begin, orf_finish, rpt_frame, last_of_run,
//                       overflow_seen
//  i_cfg_*   write      all-starts mode, start_code, stop_code
//
// A start, an ignored code or a stop in an empty frame leaves i_in open.
// A stop over n stacked starts passes through ST_READ, for the memory read,
// and ST_LOAD, to load the output register, once per start, with i_in closed;
// the stack memory has a single read port. Reset is synchronous and clears
// fill counts and flags; the stack memory is not cleared. A stalled output
// holds the next load and keeps i_in closed until the run is done.
module orf_finder_three_frame_top #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [orf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [orf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    orf_in_if.sink                         i_in,
    orf_out_if.source                      o_out
);

    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int MEM_DEPTH = orf_pkg::NUM_FRAMES * STACK_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    logic [orf_pkg::POS_W-1:0] r_mem [MEM_DEPTH];

    orf_pkg::t_state r_state;
    orf_pkg::t_state n_state;

    logic [CW-1:0]                  r_cnt [orf_pkg::NUM_FRAMES];
    logic [orf_pkg::NUM_FRAMES-1:0] r_ovf;
    logic                           r_all_starts;
    logic [orf_pkg::AMINO_W-1:0]    r_start_code;
    logic [orf_pkg::AMINO_W-1:0]    r_stop_code;

    logic [orf_pkg::FRAME_W-1:0] r_pop_frame;
    logic [CW-1:0]               r_pop_cnt;
    logic [orf_pkg::POS_W-1:0]   r_finish;
    logic                        r_pop_ovf;
    logic [orf_pkg::POS_W-1:0]   r_rd_data;

    logic                        r_out_valid;
    logic [orf_pkg::POS_W-1:0]   r_out_begin;
    logic [orf_pkg::POS_W-1:0]   r_out_finish;
    logic [orf_pkg::FRAME_W-1:0] r_out_frame;
    logic                        r_out_last;
    logic                        r_out_ovf;

    logic                           w_fire;
    logic [orf_pkg::NUM_FRAMES-1:0] w_sel;
    logic [CW-1:0]                  w_cnt;
    logic                           w_cnt_ovf;
    logic                           w_is_start;
    logic                           w_push;
    logic                           w_drop;
    logic                           w_pop;
    logic [AW-1:0]                  w_wr_addr;
    logic [AW-1:0]                  w_rd_addr;
    logic                           w_out_free;

    assign w_fire = i_in.valid && i_in.ready;

    always_comb begin
        w_sel     = '0;
        w_cnt     = '0;
        w_cnt_ovf = 1'b0;
        case (i_in.reading_frame)
            2'd0: begin
                w_sel     = 3'b001;
                w_cnt     = r_cnt[0];
                w_cnt_ovf = r_ovf[0];
            end
            2'd1: begin
                w_sel     = 3'b010;
                w_cnt     = r_cnt[1];
                w_cnt_ovf = r_ovf[1];
            end
            2'd2: begin
                w_sel     = 3'b100;
                w_cnt     = r_cnt[2];
                w_cnt_ovf = r_ovf[2];
            end
            default: begin
                w_sel     = '0;
                w_cnt     = '0;
                w_cnt_ovf = 1'b0;
            end
        endcase
    end

    assign w_is_start = (i_in.amino == r_start_code) && (r_all_starts || (w_cnt == '0));
    assign w_push = w_fire && (w_sel != '0) && w_is_start && (w_cnt < CW'(STACK_DEPTH));
    assign w_drop = w_fire && (w_sel != '0) && w_is_start && (w_cnt >= CW'(STACK_DEPTH));
    assign w_pop  = w_fire && (w_sel != '0) && !w_is_start
                    && (i_in.amino == r_stop_code) && (w_cnt != '0);

    assign w_wr_addr = AW'(i_in.reading_frame) * AW'(STACK_DEPTH) + AW'(w_cnt);
    assign w_rd_addr = AW'(r_pop_frame) * AW'(STACK_DEPTH) + AW'(r_pop_cnt - CW'(1));

    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            orf_pkg::ST_IDLE: begin
                if (w_pop) begin
                    n_state = orf_pkg::ST_READ;
                end
            end
            orf_pkg::ST_READ: begin
                n_state = orf_pkg::ST_LOAD;
            end
            orf_pkg::ST_LOAD: begin
                if (w_out_free) begin
                    n_state = (r_pop_cnt == '0) ? orf_pkg::ST_IDLE : orf_pkg::ST_READ;
                end
            end
            default: begin
                n_state = orf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[w_wr_addr] <= i_in.codon_position - orf_pkg::POS_W'(1);
        end
        if (r_state == orf_pkg::ST_READ) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= orf_pkg::ST_IDLE;
            r_ovf        <= '0;
            r_all_starts <= 1'b0;
            r_start_code <= orf_pkg::START_CODE_RST;
            r_stop_code  <= orf_pkg::STOP_CODE_RST;
            r_out_valid  <= 1'b0;
            for (int f = 0; f < orf_pkg::NUM_FRAMES; f++) begin
                r_cnt[f] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    orf_pkg::CFG_ALL_STARTS: r_all_starts <= i_cfg_data[0];
                    orf_pkg::CFG_START_CODE: r_start_code <= i_cfg_data;
                    orf_pkg::CFG_STOP_CODE:  r_stop_code  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            for (int f = 0; f < orf_pkg::NUM_FRAMES; f++) begin
                if (w_sel[f] && w_push) begin
                    r_cnt[f] <= r_cnt[f] + CW'(1);
                end
                if (w_sel[f] && w_pop) begin
                    r_cnt[f] <= '0;
                end
                if (w_sel[f] && w_drop) begin
                    r_ovf[f] <= 1'b1;
                end
                if (w_sel[f] && w_pop) begin
                    r_ovf[f] <= 1'b0;
                end
            end
            if (r_state == orf_pkg::ST_LOAD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_pop_frame <= i_in.reading_frame;
            r_pop_cnt   <= w_cnt;
            r_finish    <= i_in.codon_position - orf_pkg::POS_W'(2);
            r_pop_ovf   <= w_cnt_ovf;
        end else if (r_state == orf_pkg::ST_READ) begin
            r_pop_cnt <= r_pop_cnt - CW'(1);
        end
        if (r_state == orf_pkg::ST_LOAD && w_out_free) begin
            r_out_begin  <= r_rd_data;
            r_out_finish <= r_finish;
            r_out_frame  <= r_pop_frame;
            r_out_last   <= (r_pop_cnt == '0);
            r_out_ovf    <= r_pop_ovf;
        end
    end

    assign i_in.ready          = (r_state == orf_pkg::ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.orf_begin     = r_out_begin;
    assign o_out.orf_finish    = r_out_finish;
    assign o_out.rpt_frame     = r_out_frame;
    assign o_out.last_of_run   = r_out_last;
    assign o_out.overflow_seen = r_out_ovf;

endmodule

>>> design/orf_chk.sv
// ============================================================================
// orf_chk
// Port-level checks for the three-frame open reading frame finder.
// ============================================================================
module orf_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [orf_pkg::POS_W-1:0]   i_out_begin,
    input logic [orf_pkg::POS_W-1:0]   i_out_finish,
    input logic [orf_pkg::FRAME_W-1:0] i_out_frame,
    input logic                        i_out_last
);

    a_rst_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Output valid after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_begin)
            && $stable(i_out_finish) && $stable(i_out_frame) && $stable(i_out_last))
        else $error("Stalled output transfer changed.");

    a_run_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("Input open in the middle of a run.");

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_frame != 2'd3)
        else $error("Reported frame out of range.");

endmodule

bind orf_finder_three_frame_top orf_chk u_orf_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_begin  (o_out.orf_begin),
    .i_out_finish (o_out.orf_finish),
    .i_out_frame  (o_out.rpt_frame),
    .i_out_last   (o_out.last_of_run)
);

>>> dv/tb_orf_finder_three_frame_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_orf_finder_three_frame_top
// Drives codon streams into the three-frame open reading frame finder, keeps
// its own copy of the per-frame start stacks to work out every reported
// frame, and checks each output transfer field by field under random input
// gaps and output stalls.
// ============================================================================
module tb_orf_finder_three_frame_top;

    localparam int STACK_DEPTH    = 32;
    localparam int SETTLE_CYCLES  = 2 * STACK_DEPTH + 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [orf_pkg::POS_W-1:0]   orf_begin;
        logic [orf_pkg::POS_W-1:0]   orf_finish;
        logic [orf_pkg::FRAME_W-1:0] rpt_frame;
        logic                        last_of_run;
        logic                        overflow_seen;
    } t_orf_rec;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [orf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [orf_pkg::CFG_DATA_W-1:0] cfg_data;

    orf_in_if  in_ch ();
    orf_out_if out_ch ();

    orf_finder_three_frame_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    logic [orf_pkg::POS_W-1:0]   codon_stack [orf_pkg::NUM_FRAMES][STACK_DEPTH];
    int                          codon_fill [orf_pkg::NUM_FRAMES];
    logic                        dropped_start [orf_pkg::NUM_FRAMES];
    logic                        all_starts;
    logic [orf_pkg::AMINO_W-1:0] start_amino;
    logic [orf_pkg::AMINO_W-1:0] stop_amino;

    t_orf_rec   pending_orfs [$];
    int         mismatches;
    int         idle_cycles;
    int         burst_left;
    int         gap_max;
    logic       hold_req;
    int         hold_left;
    logic [7:0] stall_pattern;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic predict_orfs(input logic [orf_pkg::AMINO_W-1:0] amino,
                                input logic [orf_pkg::FRAME_W-1:0] frame,
                                input logic [orf_pkg::POS_W-1:0] pos);
        int                        fill;
        logic [orf_pkg::POS_W-1:0] finish;
        t_orf_rec                  rec;
        if (frame >= orf_pkg::NUM_FRAMES) return;
        fill = codon_fill[frame];
        if (amino == start_amino && (all_starts || fill == 0)) begin
            if (fill < STACK_DEPTH) begin
                codon_stack[frame][fill] = pos - 32'd1;
                codon_fill[frame] = fill + 1;
            end else begin
                dropped_start[frame] = 1'b1;
            end
            return;
        end
        if (amino == stop_amino && fill > 0) begin
            finish = pos - 32'd2;
            for (int k = fill - 1; k >= 0; k--) begin
                rec.orf_begin     = codon_stack[frame][k];
                rec.orf_finish    = finish;
                rec.rpt_frame     = frame;
                rec.last_of_run   = (k == 0);
                rec.overflow_seen = dropped_start[frame];
                pending_orfs.push_back(rec);
            end
            codon_fill[frame] = 0;
            dropped_start[frame] = 1'b0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid high unless a gap follows, so calls in a burst keep it high.
    task automatic send_codon(input logic [orf_pkg::AMINO_W-1:0] amino,
                              input logic [orf_pkg::FRAME_W-1:0] frame,
                              input logic [orf_pkg::POS_W-1:0] pos);
        int gap;
        in_ch.valid          = 1'b1;
        in_ch.amino          = amino;
        in_ch.reading_frame  = frame;
        in_ch.codon_position = pos;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_orfs(amino, frame, pos);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (pending_orfs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input orf_pkg::t_cfg_reg idx,
                             input logic [orf_pkg::CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            orf_pkg::CFG_ALL_STARTS: all_starts  = data[0];
            orf_pkg::CFG_START_CODE: start_amino = data;
            orf_pkg::CFG_STOP_CODE:  stop_amino  = data;
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_codon(orf_pkg::START_CODE_RST, 2'd3, 32'd5);
        send_codon(orf_pkg::STOP_CODE_RST, 2'd1, 32'd9);
        send_codon(orf_pkg::START_CODE_RST, 2'd0, 32'd0);
        send_codon(orf_pkg::START_CODE_RST, 2'd0, 32'd7);
        send_codon(8'd0, 2'd0, 32'd8);
        send_codon(8'd255, 2'd2, 32'hFFFF_FFFF);
        send_codon(orf_pkg::START_CODE_RST, 2'd2, 32'hFFFF_FFFF);
        send_codon(orf_pkg::STOP_CODE_RST, 2'd0, 32'd1);
        send_codon(orf_pkg::STOP_CODE_RST, 2'd2, 32'h8000_0000);
        send_codon(orf_pkg::STOP_CODE_RST, 2'd3, 32'h5555_5555);
        drain_results();
    endtask

    task automatic test_all_starts();
        write_reg(orf_pkg::CFG_ALL_STARTS, 8'd1);
        send_codon(start_amino, 2'd1, 32'd10);
        send_codon(start_amino, 2'd1, 32'd13);
        send_codon(start_amino, 2'd1, 32'd16);
        send_codon(start_amino, 2'd0, 32'd20);
        send_codon(stop_amino, 2'd1, 32'd22);
        send_codon(stop_amino, 2'd0, 32'd23);
        drain_results();
    endtask

    task automatic test_code_extremes();
        write_reg(orf_pkg::CFG_START_CODE, 8'd0);
        write_reg(orf_pkg::CFG_STOP_CODE, 8'd255);
        send_codon(8'd0, 2'd2, 32'd100);
        send_codon(orf_pkg::START_CODE_RST, 2'd2, 32'd103);
        send_codon(8'd255, 2'd2, 32'd200);
        drain_results();
        write_reg(orf_pkg::CFG_START_CODE, 8'd255);
        write_reg(orf_pkg::CFG_STOP_CODE, 8'd0);
        send_codon(8'd255, 2'd1, 32'd50);
        send_codon(8'd0, 2'd1, 32'd60);
        drain_results();
    endtask

    task automatic test_equal_codes();
        write_reg(orf_pkg::CFG_ALL_STARTS, 8'd0);
        write_reg(orf_pkg::CFG_START_CODE, 8'd200);
        write_reg(orf_pkg::CFG_STOP_CODE, 8'd200);
        send_codon(8'd200, 2'd0, 32'd300);
        send_codon(8'd200, 2'd0, 32'd303);
        send_codon(8'd200, 2'd0, 32'd306);
        drain_results();
        write_reg(orf_pkg::CFG_ALL_STARTS, 8'd1);
        send_codon(8'd200, 2'd0, 32'd309);
        drain_results();
        write_reg(orf_pkg::CFG_STOP_CODE, orf_pkg::STOP_CODE_RST);
        send_codon(orf_pkg::STOP_CODE_RST, 2'd0, 32'd312);
        drain_results();
    endtask

    task automatic test_stack_overflow();
        write_reg(orf_pkg::CFG_START_CODE, orf_pkg::START_CODE_RST);
        for (int k = 0; k < STACK_DEPTH + 3; k++) begin
            send_codon(orf_pkg::START_CODE_RST, 2'd2, 32'd1000 + 3 * k);
        end
        send_codon(orf_pkg::STOP_CODE_RST, 2'd0, 32'd1200);
        send_codon(orf_pkg::STOP_CODE_RST, 2'd2, 32'd1202);
        send_codon(orf_pkg::START_CODE_RST, 2'd2, 32'd1205);
        send_codon(orf_pkg::STOP_CODE_RST, 2'd2, 32'd1208);
        drain_results();
    endtask

    // The output is held off while starts and a stop are offered, so the
    // flush stalls and the block must close its input until the hold ends.
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++) begin
            send_codon(start_amino, 2'd1, 32'd4000 + 3 * k);
        end
        send_codon(stop_amino, 2'd1, 32'd4040);
        for (int k = 0; k < 20; k++) begin
            send_codon((k % 3 == 2) ? stop_amino : start_amino, 2'((k % 2) * 2),
                       32'd4100 + k);
        end
        drain_results();
    endtask

    task automatic test_random_streams();
        int                          items;
        int                          r;
        logic [orf_pkg::POS_W-1:0]   pos;
        logic [orf_pkg::FRAME_W-1:0] frame;
        logic [orf_pkg::AMINO_W-1:0] amino;
        items = 0;
        pos   = $urandom();
        while (items < 20) begin
            if (items % 10 == 0) begin
                drain_results();
                write_reg(orf_pkg::CFG_ALL_STARTS, 8'($urandom_range(0, 1)));
                case ($urandom_range(0, 3))
                    0:       write_reg(orf_pkg::CFG_START_CODE, 8'd0);
                    1:       write_reg(orf_pkg::CFG_START_CODE, 8'd255);
                    default: write_reg(orf_pkg::CFG_START_CODE, 8'($urandom()));
                endcase
                if ($urandom_range(0, 4) == 0) write_reg(orf_pkg::CFG_STOP_CODE, start_amino);
                else write_reg(orf_pkg::CFG_STOP_CODE, 8'($urandom()));
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if ($urandom_range(0, 3) == 0) pos = 32'hFFFF_FFF8;
            end
            pos = ($urandom_range(0, 19) == 0) ? $urandom() : pos + 32'd1;
            r = $urandom_range(0, 99);
            if (r < 5) frame = 2'd3;
            else if (r < 15) frame = 2'($urandom_range(0, 2));
            else frame = 2'(pos % 3);
            r = $urandom_range(0, 99);
            if (r < 40) amino = start_amino;
            else if (r < 65) amino = stop_amino;
            else amino = 8'($urandom());
            send_codon(amino, frame, pos);
            if (frame < orf_pkg::NUM_FRAMES) items++;
        end
        drain_results();
    endtask

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = orf_pkg::CFG_ALL_STARTS;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.amino          = '0;
        in_ch.reading_frame  = '0;
        in_ch.codon_position = '0;
        hold_req             = 1'b0;
        all_starts           = 1'b0;
        start_amino          = orf_pkg::START_CODE_RST;
        stop_amino           = orf_pkg::STOP_CODE_RST;
        mismatches           = 0;
        burst_left           = 0;
        gap_max              = 3;
        for (int f = 0; f < orf_pkg::NUM_FRAMES; f++) begin
            codon_fill[f]    = 0;
            dropped_start[f] = 1'b0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_all_starts();
        test_code_extremes();
        test_equal_codes();
        test_stack_overflow();
        test_output_backpressure();
        test_random_streams();

        drain_results();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: a repeating ready pattern that is redrawn while no hold-off runs,
    // and a long hold-off whenever one is requested.
    initial begin
        int pat_idx;
        out_ch.ready  = 1'b0;
        hold_left     = 0;
        pat_idx       = 0;
        stall_pattern = 8'hFF;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = stall_pattern[pat_idx % 8];
                pat_idx++;
                if (pat_idx % 64 == 0) begin
                    stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF
                                  : (8'($urandom()) | 8'h01);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_orf_rec want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            if (pending_orfs.size() == 0) begin
                $error("unexpected transfer: orf_begin %h orf_finish %h rpt_frame %0d",
                       out_ch.orf_begin, out_ch.orf_finish, out_ch.rpt_frame);
                mismatches++;
            end else begin
                want = pending_orfs.pop_front();
                if (out_ch.orf_begin !== want.orf_begin) begin
                    $error("orf_begin: expected %h, actual %h", want.orf_begin,
                           out_ch.orf_begin);
                    mismatches++;
                end
                if (out_ch.orf_finish !== want.orf_finish) begin
                    $error("orf_finish: expected %h, actual %h", want.orf_finish,
                           out_ch.orf_finish);
                    mismatches++;
                end
                if (out_ch.rpt_frame !== want.rpt_frame) begin
                    $error("rpt_frame: expected %0d, actual %0d", want.rpt_frame,
                           out_ch.rpt_frame);
                    mismatches++;
                end
                if (out_ch.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %b, actual %b", want.last_of_run,
                           out_ch.last_of_run);
                    mismatches++;
                end
                if (out_ch.overflow_seen !== want.overflow_seen) begin
                    $error("overflow_seen: expected %b, actual %b", want.overflow_seen,
                           out_ch.overflow_seen);
                    mismatches++;
                end
            end
        end
    end

    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
design/orf_pkg.sv
design/orf_in_if.sv
design/orf_out_if.sv
design/orf_finder_three_frame_top.sv
design/orf_chk.sv
dv/tb_orf_finder_three_frame_top.sv
